/* src/brhp_pkg.sv */
// Shared types, codes and constants of the byte-range header parser.
`timescale 1ns / 1ps
package brhp_pkg;

   // Field widths of the request and response beats.
   localparam int CH_W   = 8;
   localparam int SIZE_W = 63;
   localparam int VAL_W  = 64;
   localparam int KIND_W = 2;

   // Parser phase codes.
   localparam logic [2:0] PH_PREFIX   = 3'd0;
   localparam logic [2:0] PH_START_WS = 3'd1;
   localparam logic [2:0] PH_START    = 3'd2;
   localparam logic [2:0] PH_SEP_WS   = 3'd3;
   localparam logic [2:0] PH_END_WS   = 3'd4;
   localparam logic [2:0] PH_END      = 3'd5;

   // Range kind codes reported on the response.
   localparam logic [KIND_W-1:0] KIND_FULL    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

   // Numeric limits.
   localparam logic [VAL_W-1:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [VAL_W-1:0] LIMIT_DIV10 = 64'd922337203685477580;
   localparam logic [3:0] POS_LAST_DIGIT = 4'd7;
   localparam logic [3:0] NEG_LAST_DIGIT = 4'd8;

   // Characters of interest.
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

   localparam logic [2:0] PREFIX_LEN = 3'd6;

   // Parse state carried across header characters.
   typedef struct packed {
      logic [2:0]       phase;
      logic [2:0]       prefix_pos;
      logic [VAL_W-1:0] start_mag;
      logic [VAL_W-1:0] end_mag;
      logic             start_neg;
      logic             end_neg;
      logic             digits_seen;
      logic             overflowed;
      logic             invalid;
   } brhp_parse_type;

   localparam brhp_parse_type PARSE_RESET = '{
      phase:       PH_PREFIX,
      prefix_pos:  3'd0,
      start_mag:   64'd0,
      end_mag:     MAX_POS,
      start_neg:   1'b0,
      end_neg:     1'b0,
      digits_seen: 1'b0,
      overflowed:  1'b0,
      invalid:     1'b0
   };

   // Final parse state of one header, handed to the resolver.
   typedef struct packed {
      logic              no_header;
      logic [SIZE_W-1:0] content_size;
      brhp_parse_type    parse;
   } brhp_snap_type;

   // Expected character of the "bytes=" prefix at a given position.
   function automatic logic [CH_W-1:0] prefix_char(input logic [2:0] pos);
      logic [CH_W-1:0] c;
      unique case (pos)
         3'd0: c = 8'h62;  // b
         3'd1: c = 8'h79;  // y
         3'd2: c = 8'h74;  // t
         3'd3: c = 8'h65;  // e
         3'd4: c = 8'h73;  // s
         3'd5: c = 8'h3D;  // =
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* src/brhp_req_if.sv */
// Request channel: one header character per beat.
`timescale 1ns / 1ps
interface brhp_req_if import brhp_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [CH_W-1:0]   ch;
   logic              last_char;
   logic              no_header;
   logic [SIZE_W-1:0] content_size;

   modport source (output valid, ch, last_char, no_header, content_size, input ready);
   modport sink   (input valid, ch, last_char, no_header, content_size, output ready);
endinterface

/* src/brhp_rsp_if.sv */
// Response channel: one resolved range per beat.
`timescale 1ns / 1ps
interface brhp_rsp_if import brhp_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] range_kind;
   logic [VAL_W-1:0]  first_byte;
   logic [VAL_W-1:0]  last_byte;

   modport source (output valid, range_kind, first_byte, last_byte, input ready);
   modport sink   (input valid, range_kind, first_byte, last_byte, output ready);
endinterface

/* src/byte_range_header_parse_resolve.sv */
// Path: a closing request beat is captured in the snap register, then passes the mid and
// output registers of the resolver before its result beat goes valid.
// Throughput: one request beat per cycle while ready is high; a waiting result does not block intake
// until the three-deep snap, mid and output pipeline fills.
// The parse state update per character (multiply-by-ten accumulate) sets the cycle.
// Synchronous reset clears the parse state and every stage valid flag.
`timescale 1ns / 1ps
module byte_range_header_parse_resolve import brhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   brhp_req_if.sink   req_bus,
   brhp_rsp_if.source rsp_bus
);

   logic          snap_valid, snap_ready;
   brhp_snap_type snap;

   // Character parser with captured end-of-header state.
   brhp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   // Range check and clamp.
   brhp_resolver u_resolver (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap),
      .rsp_bus    (rsp_bus)
   );

   // A closing beat always leaves a captured state behind.
   assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && (req_bus.last_char || req_bus.no_header)
      |=> snap_valid)
      else $error("closing beat not captured");

   // Full and invalid results start at offset zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.range_kind != KIND_PARTIAL) |-> (rsp_bus.first_byte == '0))
      else $error("nonzero first byte on full or invalid result");

   // A resolved partial range never starts before the content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.range_kind == KIND_PARTIAL) |-> !rsp_bus.first_byte[VAL_W-1])
      else $error("negative first byte on partial result");

   // Only defined kind codes leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.range_kind == KIND_FULL) ||
                        (rsp_bus.range_kind == KIND_PARTIAL) ||
                        (rsp_bus.range_kind == KIND_INVALID))
      else $error("undefined range kind");

endmodule

/* src/brhp_parser.sv */
// Character parser: updates the parse state per beat and captures it at header end.
`timescale 1ns / 1ps
module brhp_parser import brhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   brhp_req_if.sink      req_bus,
   output logic          snap_valid,
   input  logic          snap_ready,
   output brhp_snap_type snap
);

   brhp_parse_type state_ff, state_in, parse_next;
   brhp_snap_type  snap_ff;
   logic           snap_valid_ff, snap_valid_in;

   logic             accept, resolve;
   logic [CH_W-1:0]  ch;
   logic             is_blank, is_digit, is_sign;
   logic [3:0]       digit;
   logic [VAL_W-1:0] acc_base, acc_mag;
   logic             acc_neg, acc_ovf_base, acc_over;
   logic             end_side;

   assign ch      = req_bus.ch;
   assign req_bus.ready = !snap_valid_ff || snap_ready;
   assign accept  = req_bus.valid && req_bus.ready;
   assign resolve = req_bus.last_char || req_bus.no_header;

   // Character classes.
   assign is_blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
   assign digit    = ch[3:0];

   // Shared decimal accumulator; an end number starts from zero in the blank phase.
   assign end_side     = (state_ff.phase == PH_END) || (state_ff.phase == PH_END_WS);
   assign acc_base     = (state_ff.phase == PH_END) ? state_ff.end_mag :
                         (state_ff.phase == PH_END_WS) ? '0 : state_ff.start_mag;
   assign acc_ovf_base = (state_ff.phase == PH_END_WS) ? 1'b0 : state_ff.overflowed;
   assign acc_neg      = end_side ? state_ff.end_neg : state_ff.start_neg;
   assign acc_over     = (acc_base > LIMIT_DIV10) ||
                         ((acc_base == LIMIT_DIV10) &&
                          (digit > (acc_neg ? NEG_LAST_DIGIT : POS_LAST_DIGIT)));
   assign acc_mag      = (acc_base << 3) + (acc_base << 1) + {60'd0, digit};

   // Next parse state for the current character.
   always_comb begin
      parse_next = state_ff;
      if (!state_ff.invalid) begin
         unique case (state_ff.phase)
            PH_PREFIX: begin
               if ((state_ff.prefix_pos < PREFIX_LEN) &&
                   (ch == prefix_char(state_ff.prefix_pos))) begin
                  parse_next.prefix_pos = state_ff.prefix_pos + 3'd1;
                  if (state_ff.prefix_pos == PREFIX_LEN - 3'd1) begin
                     parse_next.phase = PH_START_WS;
                  end
               end else begin
                  parse_next.invalid = 1'b1;
               end
            end
            PH_START_WS, PH_START: begin
               if (state_ff.phase == PH_START_WS && is_blank) begin
                  parse_next = state_ff;
               end else if (state_ff.phase == PH_START_WS && is_sign) begin
                  parse_next.phase     = PH_START;
                  parse_next.start_neg = (ch == CH_MINUS);
               end else if (is_digit) begin
                  parse_next.phase       = PH_START;
                  parse_next.digits_seen = 1'b1;
                  if (!acc_ovf_base) begin
                     if (acc_over) begin
                        parse_next.overflowed = 1'b1;
                     end else begin
                        parse_next.start_mag = acc_mag;
                     end
                  end
               end else if (state_ff.phase == PH_START_WS) begin
                  parse_next.phase   = PH_START;
                  parse_next.invalid = 1'b1;
               end else if (!state_ff.digits_seen || state_ff.overflowed ||
                            (state_ff.start_neg && (state_ff.start_mag != '0))) begin
                  parse_next.invalid = 1'b1;
               end else if (is_blank) begin
                  parse_next.phase = PH_SEP_WS;
               end else if (ch == CH_MINUS) begin
                  parse_next.phase = PH_END_WS;
               end else begin
                  parse_next.invalid = 1'b1;
               end
            end
            PH_SEP_WS: begin
               if (!is_blank) begin
                  if (ch == CH_MINUS) begin
                     parse_next.phase = PH_END_WS;
                  end else begin
                     parse_next.invalid = 1'b1;
                  end
               end
            end
            PH_END_WS, PH_END: begin
               if (state_ff.phase == PH_END_WS && is_blank) begin
                  parse_next = state_ff;
               end else begin
                  parse_next.phase = PH_END;
                  if (state_ff.phase == PH_END_WS) begin
                     parse_next.end_mag     = '0;
                     parse_next.digits_seen = 1'b0;
                     parse_next.overflowed  = 1'b0;
                  end
                  if (state_ff.phase == PH_END_WS && is_sign) begin
                     parse_next.end_neg = (ch == CH_MINUS);
                  end else if (is_digit) begin
                     parse_next.digits_seen = 1'b1;
                     if (!acc_ovf_base) begin
                        if (acc_over) begin
                           parse_next.overflowed = 1'b1;
                        end else begin
                           parse_next.end_mag = acc_mag;
                        end
                     end
                  end else begin
                     parse_next.invalid = 1'b1;
                  end
               end
            end
            default: begin
               parse_next.invalid = 1'b1;
            end
         endcase
      end
   end

   // State returns to reset after every header end.
   always_comb begin
      state_in      = state_ff;
      snap_valid_in = snap_valid_ff && !snap_ready;
      if (accept) begin
         state_in = resolve ? PARSE_RESET : parse_next;
         if (resolve) begin
            snap_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PARSE_RESET;
         snap_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // Captured final state of the header.
   always_ff @(posedge clock) begin
      if (accept && resolve) begin
         snap_ff.no_header    <= req_bus.no_header;
         snap_ff.content_size <= req_bus.content_size;
         snap_ff.parse        <= parse_next;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

/* src/brhp_resolver.sv */
// Resolver: checks the finished parse and clamps the range against the content size.
`timescale 1ns / 1ps
module brhp_resolver import brhp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          snap_valid,
   output logic          snap_ready,
   input  brhp_snap_type snap,
   brhp_rsp_if.source    rsp_bus
);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [VAL_W-1:0]  first;
      logic [VAL_W-1:0]  last;
      logic [SIZE_W-1:0] content_size;
   } brhp_mid_type;

   brhp_mid_type     mid_ff, mid_in;
   logic             mid_valid_ff, mid_valid_in;
   logic             out_valid_ff, out_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [VAL_W-1:0] first_ff, first_in, last_ff, last_in;
   logic             out_ready, mid_ready;
   logic [VAL_W-1:0] start_s, end_s, size_ext, size_m1, size_plus;
   logic             ok;

   assign out_ready  = !out_valid_ff || rsp_bus.ready;
   assign mid_ready  = !mid_valid_ff || out_ready;
   assign snap_ready = mid_ready;

   // First half: signed start and end, and whether the header parsed.
   always_comb begin
      start_s = snap.parse.start_neg ? (64'd0 - snap.parse.start_mag) : snap.parse.start_mag;
      if (snap.parse.overflowed) begin
         end_s = snap.parse.end_neg ? SIGN_BIT : MAX_POS;
      end else begin
         end_s = snap.parse.end_neg ? (64'd0 - snap.parse.end_mag) : snap.parse.end_mag;
      end
      mid_in.content_size = snap.content_size;
      mid_in.first        = start_s;
      mid_in.last         = MAX_POS;
      ok                  = 1'b0;
      if (!snap.parse.invalid) begin
         unique case (snap.parse.phase)
            PH_START:  ok = snap.parse.digits_seen && !snap.parse.overflowed && start_s[VAL_W-1];
            PH_END_WS: ok = 1'b1;
            PH_END: begin
               ok          = ($signed(start_s) <= $signed(end_s));
               mid_in.last = end_s;
            end
            default:   ok = 1'b0;
         endcase
      end
      if (snap.no_header) begin
         mid_in.kind = KIND_FULL;
      end else if (ok) begin
         mid_in.kind = KIND_PARTIAL;
      end else begin
         mid_in.kind = KIND_INVALID;
      end
   end

   // Second half: clamp against the content size.
   always_comb begin
      size_ext  = {1'b0, mid_ff.content_size};
      size_m1   = size_ext - 64'd1;
      size_plus = size_ext + mid_ff.first;
      kind_in   = mid_ff.kind;
      first_in  = '0;
      last_in   = size_m1;
      if (mid_ff.kind == KIND_PARTIAL) begin
         if (!mid_ff.first[VAL_W-1]) begin
            first_in = mid_ff.first;
         end else if (!size_plus[VAL_W-1]) begin
            first_in = size_plus;
         end
         if ($signed(size_m1) > $signed(mid_ff.last)) begin
            last_in = mid_ff.last;
         end
      end
   end

   // Stage valid flags.
   always_comb begin
      mid_valid_in = snap_valid || (mid_valid_ff && !out_ready);
      if (!mid_ready) begin
         mid_valid_in = mid_valid_ff;
      end
      out_valid_in = out_ready ? mid_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_ready) begin
         mid_ff <= mid_in;
      end
      if (out_ready) begin
         kind_ff  <= kind_in;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.range_kind = kind_ff;
   assign rsp_bus.first_byte = first_ff;
   assign rsp_bus.last_byte  = last_ff;

endmodule
